// ===== rtl/lgpc_pkg.sv =====
`default_nettype none

package lgpc_pkg;

   // Text and line limits.
   localparam int LINE_MAX    = 1024;
   localparam int PATTERN_MAX = 32;
   localparam int BYTE_W      = 8;

   // Position counter only has to reach LINE_MAX-2 before the forced line end.
   localparam int POS_W   = $clog2(LINE_MAX - 1);
   localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
   localparam int TALLY_W = 10;
   localparam int TOTAL_W = 32;

   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
   localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(LINE_MAX - 2);

   // Pattern storage: four 64-bit words of eight bytes each.
   localparam int WORD_COUNT  = 4;
   localparam int WORD_W      = 64;
   localparam int WORD_BYTES  = WORD_W / BYTE_W;
   localparam int STORED_BYTES = WORD_COUNT * WORD_BYTES;

   // Register port geometry: 64-bit registers at 8-byte spacing.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_SEL_LO = 3;

   localparam logic [BYTE_W-1:0] UNDERSCORE_CHAR = 8'h5F;
   localparam logic [BYTE_W-1:0] PIPE_CHAR       = 8'h7C;

   typedef enum logic [CSR_ADDR_W-CSR_SEL_LO-1:0] {
      REG_PATTERN_LENGTH  = 3'd0,
      REG_PATTERN_BYTES_0 = 3'd1,
      REG_PATTERN_BYTES_1 = 3'd2,
      REG_PATTERN_BYTES_2 = 3'd3,
      REG_PATTERN_BYTES_3 = 3'd4
   } reg_index_type;

   typedef logic [PATTERN_MAX-1:0][BYTE_W-1:0] pattern_type;

   // Settings seen by the datapath.
   typedef struct packed {
      logic [LEN_W-1:0] len;       // effective length, 1 to PATTERN_MAX
      pattern_type      pattern;   // byte k of the pattern at index k
   } cfg_type;

   // One text item held in the input register.
   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              line_end;
   } item_type;

   // Pipeline control from the line tracker.
   typedef struct packed {
      logic advance;     // the held item is processed this cycle
      logic line_done;   // the held item finishes its line
   } step_type;

endpackage

`default_nettype wire

// ===== rtl/lgpc_csr.sv =====
`default_nettype none

module lgpc_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [lgpc_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [lgpc_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic      [lgpc_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                        csr_pready,
   output lgpc_pkg::cfg_type                           cfg
);

   logic [lgpc_pkg::LEN_W-1:0]  pattern_length_ff;
   logic [lgpc_pkg::LEN_W-1:0]  pattern_length_in;
   logic [lgpc_pkg::WORD_COUNT-1:0][lgpc_pkg::WORD_W-1:0] pattern_words_ff;
   logic [lgpc_pkg::WORD_COUNT-1:0][lgpc_pkg::WORD_W-1:0] pattern_words_in;
   lgpc_pkg::reg_index_type reg_index;
   logic                    write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = lgpc_pkg::reg_index_type'(
                          csr_paddr[lgpc_pkg::CSR_ADDR_W-1:lgpc_pkg::CSR_SEL_LO]);

   // Register writes; indexes past the last register are ignored.
   always_comb begin
      pattern_length_in = pattern_length_ff;
      pattern_words_in  = pattern_words_ff;
      if (write_en) begin
         unique case (reg_index)
            lgpc_pkg::REG_PATTERN_LENGTH:
               pattern_length_in = csr_pwdata[lgpc_pkg::LEN_W-1:0];
            lgpc_pkg::REG_PATTERN_BYTES_0: pattern_words_in[0] = csr_pwdata;
            lgpc_pkg::REG_PATTERN_BYTES_1: pattern_words_in[1] = csr_pwdata;
            lgpc_pkg::REG_PATTERN_BYTES_2: pattern_words_in[2] = csr_pwdata;
            lgpc_pkg::REG_PATTERN_BYTES_3: pattern_words_in[3] = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= lgpc_pkg::LEN_W'(1);
         pattern_words_ff  <= '0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         pattern_words_ff  <= pattern_words_in;
      end
   end

   // Read data.
   always_comb begin
      unique case (reg_index)
         lgpc_pkg::REG_PATTERN_LENGTH:
            csr_prdata = lgpc_pkg::CSR_DATA_W'(pattern_length_ff);
         lgpc_pkg::REG_PATTERN_BYTES_0: csr_prdata = pattern_words_ff[0];
         lgpc_pkg::REG_PATTERN_BYTES_1: csr_prdata = pattern_words_ff[1];
         lgpc_pkg::REG_PATTERN_BYTES_2: csr_prdata = pattern_words_ff[2];
         lgpc_pkg::REG_PATTERN_BYTES_3: csr_prdata = pattern_words_ff[3];
         default:                       csr_prdata = '0;
      endcase
   end

   // Effective length: zero reads as one, anything above the maximum is clamped.
   always_comb begin
      if (pattern_length_ff == '0) begin
         cfg.len = lgpc_pkg::LEN_W'(1);
      end else if (pattern_length_ff > lgpc_pkg::LEN_W'(lgpc_pkg::PATTERN_MAX)) begin
         cfg.len = lgpc_pkg::LEN_W'(lgpc_pkg::PATTERN_MAX);
      end else begin
         cfg.len = pattern_length_ff;
      end
   end

   // Unpack the words into pattern bytes; bytes beyond storage read as zero.
   always_comb begin
      for (int k = 0; k < lgpc_pkg::PATTERN_MAX; k++) begin
         if (k < lgpc_pkg::STORED_BYTES) begin
            cfg.pattern[k] = pattern_words_ff[k / lgpc_pkg::WORD_BYTES]
                                [(k % lgpc_pkg::WORD_BYTES) * lgpc_pkg::BYTE_W +:
                                 lgpc_pkg::BYTE_W];
         end else begin
            cfg.pattern[k] = '0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lgpc_window.sv =====
`default_nettype none

module lgpc_window (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lgpc_pkg::cfg_type  cfg,
   input  wire lgpc_pkg::item_type item,
   input  wire lgpc_pkg::step_type step,
   output logic                    hit
);

   localparam int HIST = lgpc_pkg::PATTERN_MAX - 1;

   // Previous bytes of the line, newest at index 0.
   logic [HIST-1:0][lgpc_pkg::BYTE_W-1:0] recent_ff;
   logic [HIST-1:0][lgpc_pkg::BYTE_W-1:0] recent_in;

   lgpc_pkg::pattern_type window;
   lgpc_pkg::pattern_type reversed;
   lgpc_pkg::pattern_type aligned;
   logic [lgpc_pkg::LEN_W-1:0] shift;
   logic [lgpc_pkg::PATTERN_MAX-1:0] byte_ok;

   // Window position j holds the byte j places back; the new byte is position 0.
   always_comb begin
      window[0] = item.text_byte;
      for (int j = 1; j < lgpc_pkg::PATTERN_MAX; j++) begin
         window[j] = recent_ff[j-1];
      end
   end

   // Reverse the pattern and shift it so that position j meets byte len-1-j.
   always_comb begin
      for (int j = 0; j < lgpc_pkg::PATTERN_MAX; j++) begin
         reversed[j] = cfg.pattern[lgpc_pkg::PATTERN_MAX-1-j];
      end
   end

   assign shift   = lgpc_pkg::LEN_W'(lgpc_pkg::PATTERN_MAX) - cfg.len;
   assign aligned = reversed >> (shift * lgpc_pkg::BYTE_W);

   // Parallel byte compares; positions past the pattern length always pass.
   always_comb begin
      for (int j = 0; j < lgpc_pkg::PATTERN_MAX; j++) begin
         byte_ok[j] = (window[j] == aligned[j]) ||
                      (lgpc_pkg::LEN_W'(j) >= cfg.len);
      end
   end

   assign hit = &byte_ok;

   // History shifts on each processed byte and empties at a line end.
   always_comb begin
      recent_in = recent_ff;
      if (step.advance) begin
         if (step.line_done) begin
            recent_in = '0;
         end else begin
            recent_in[0] = item.text_byte;
            for (int j = 1; j < HIST; j++) begin
               recent_in[j] = recent_ff[j-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
      end else begin
         recent_ff <= recent_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lgpc_line.sv =====
`default_nettype none

module lgpc_line (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lgpc_pkg::cfg_type                 cfg,
   input  wire logic                              item_valid,
   input  wire lgpc_pkg::item_type                item,
   input  wire logic                              hit,
   output lgpc_pkg::step_type                     step,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [lgpc_pkg::TALLY_W-1:0]           rsp_line_matches,
   output logic                                   rsp_header_valid,
   output logic [lgpc_pkg::TOTAL_W-1:0]           rsp_total_matches
);

   logic [lgpc_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [lgpc_pkg::TALLY_W-1:0] tally_ff, tally_in;
   logic                         us_seen_ff, us_seen_in;
   logic                         pipe_seen_ff, pipe_seen_in;
   logic                         us_first_ff, us_first_in;
   logic [lgpc_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lgpc_pkg::TALLY_W-1:0] matches_ff, matches_in;
   logic                         header_ff, header_in;
   logic [lgpc_pkg::TOTAL_W-1:0] out_total_ff, out_total_in;

   logic                         line_done;
   logic                         window_full;
   logic                         counted;
   logic [lgpc_pkg::TALLY_W-1:0] tally_next;
   logic                         is_us, is_pipe;
   logic                         us_seen_next, pipe_seen_next, us_first_next;
   logic                         header_ok;
   logic [lgpc_pkg::TALLY_W-1:0] kept;
   logic [lgpc_pkg::TOTAL_W:0]   total_sum;
   logic [lgpc_pkg::TOTAL_W-1:0] total_next;

   // The held item ends its line on the flag or when the line reaches its limit.
   assign line_done = item.line_end || (pos_ff == lgpc_pkg::POS_LAST);

   // A line-ending item waits only while the result register is occupied and stalled.
   assign step.advance   = item_valid && (!line_done || !rsp_valid_ff || !rsp_stall);
   assign step.line_done = line_done;

   // Count a match only once the line holds enough bytes for the whole pattern.
   assign window_full = ({1'b0, pos_ff} + (lgpc_pkg::POS_W+1)'(1)) >=
                        (lgpc_pkg::POS_W+1)'(cfg.len);
   assign counted     = hit && window_full && (tally_ff != lgpc_pkg::TALLY_MAX);
   assign tally_next  = tally_ff + lgpc_pkg::TALLY_W'(counted);

   // Header flags: the first underscore must come before the first pipe.
   assign is_us          = item.text_byte == lgpc_pkg::UNDERSCORE_CHAR;
   assign is_pipe        = item.text_byte == lgpc_pkg::PIPE_CHAR;
   assign us_seen_next   = us_seen_ff || is_us;
   assign us_first_next  = us_first_ff || (is_us && !us_seen_ff && !pipe_seen_ff);
   assign pipe_seen_next = pipe_seen_ff || is_pipe;
   assign header_ok      = us_first_next && pipe_seen_next;

   // Saturating running total.
   assign kept       = header_ok ? tally_next : '0;
   assign total_sum  = {1'b0, total_ff} + (lgpc_pkg::TOTAL_W+1)'(kept);
   assign total_next = total_sum[lgpc_pkg::TOTAL_W] ? '1 :
                       total_sum[lgpc_pkg::TOTAL_W-1:0];

   // Per-line state update.
   always_comb begin
      pos_in       = pos_ff;
      tally_in     = tally_ff;
      us_seen_in   = us_seen_ff;
      pipe_seen_in = pipe_seen_ff;
      us_first_in  = us_first_ff;
      total_in     = total_ff;
      if (step.advance) begin
         if (line_done) begin
            pos_in       = '0;
            tally_in     = '0;
            us_seen_in   = 1'b0;
            pipe_seen_in = 1'b0;
            us_first_in  = 1'b0;
            total_in     = total_next;
         end else begin
            pos_in       = pos_ff + lgpc_pkg::POS_W'(1);
            tally_in     = tally_next;
            us_seen_in   = us_seen_next;
            pipe_seen_in = pipe_seen_next;
            us_first_in  = us_first_next;
         end
      end
   end

   // Result register: loaded at a line end, emptied by a transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      matches_in   = matches_ff;
      header_in    = header_ff;
      out_total_in = out_total_ff;
      if (step.advance && line_done) begin
         rsp_valid_in = 1'b1;
         matches_in   = kept;
         header_in    = header_ok;
         out_total_in = total_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         tally_ff     <= '0;
         us_seen_ff   <= 1'b0;
         pipe_seen_ff <= 1'b0;
         us_first_ff  <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         tally_ff     <= tally_in;
         us_seen_ff   <= us_seen_in;
         pipe_seen_ff <= pipe_seen_in;
         us_first_ff  <= us_first_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      matches_ff   <= matches_in;
      header_ff    <= header_in;
      out_total_ff <= out_total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_matches  = matches_ff;
   assign rsp_header_valid  = header_ff;
   assign rsp_total_matches = out_total_ff;

endmodule

`default_nettype wire

// ===== rtl/line_gated_pattern_counter_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_text_byte[7:0], req_line_end
// rsp       out        rsp_valid/rsp_stall  rsp_line_matches[9:0], rsp_header_valid,
//                                           rsp_total_matches[31:0]
// csr       in/out     csr_psel/csr_penable pattern length and four 64-bit pattern words
//
// One byte is taken every cycle unless a line-ending byte waits on a stalled result
// register. A byte waits in the input register, where the 32 parallel window compares
// and the line counters process it; a line result is then registered in the result
// register, from which it transfers.
// Synchronous reset clears the history, counters and running total at once.
// Only a line-ending byte waits on a stalled result register; other bytes keep flowing.
module line_gated_pattern_counter_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [lgpc_pkg::BYTE_W-1:0]         req_text_byte,
   input  wire logic                                req_line_end,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [lgpc_pkg::TALLY_W-1:0]             rsp_line_matches,
   output logic                                     rsp_header_valid,
   output logic [lgpc_pkg::TOTAL_W-1:0]             rsp_total_matches,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [lgpc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [lgpc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lgpc_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   lgpc_pkg::cfg_type  cfg;
   lgpc_pkg::step_type step;
   lgpc_pkg::item_type item_ff, item_in;
   logic               item_valid_ff, item_valid_in;
   logic               hit;
   logic               req_take;

   // Input register: refills whenever it is empty or its item moves on.
   assign req_stall = item_valid_ff && !step.advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !step.advance;
      if (req_take) begin
         item_in.text_byte = req_text_byte;
         item_in.line_end  = req_line_end;
         item_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

   lgpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lgpc_window u_window (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .item  (item_ff),
      .step  (step),
      .hit   (hit)
   );

   lgpc_line u_line (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .item_valid        (item_valid_ff),
      .item              (item_ff),
      .hit               (hit),
      .step              (step),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_line_matches  (rsp_line_matches),
      .rsp_header_valid  (rsp_header_valid),
      .rsp_total_matches (rsp_total_matches)
   );

endmodule

`default_nettype wire

// ===== rtl/lgpc_checker.sv =====
`default_nettype none

module lgpc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [lgpc_pkg::TALLY_W-1:0]    rsp_line_matches,
   input wire logic                            rsp_header_valid,
   input wire logic [lgpc_pkg::TOTAL_W-1:0]    rsp_total_matches
);

   // Coming out of reset, no result is pending and the input side is open.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result pending or input stalled right after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_line_matches) && $stable(rsp_header_valid) &&
          $stable(rsp_total_matches)))
      else $error("stalled result changed");

   // A line whose header fails contributes nothing.
   a_gate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_header_valid) |-> (rsp_line_matches == '0))
      else $error("line count passed with a failed header");

   // The running total already includes this line's count.
   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_total_matches >= lgpc_pkg::TOTAL_W'(rsp_line_matches)))
      else $error("running total below line count");

   // Back-to-back results never show the running total going down.
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      ((rsp_valid && !rsp_stall) ##1 rsp_valid) |->
         (rsp_total_matches >= $past(rsp_total_matches)))
      else $error("running total decreased");

endmodule

bind line_gated_pattern_counter_unit lgpc_checker u_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
module tb;

   localparam int NUM_ROWS      = 21;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 10;
   localparam int STALL_LIMIT   = 1000;
   localparam int LONG_HOLD     = 60;
   localparam int RANDOM_ITEMS  = 400;
   localparam int RANDOM_LINES  = 40;
   localparam int TAIL_LINES    = 8;
   localparam int MAX_REPORTS   = 40;

   // Register indexes past the pattern words are unmapped.
   localparam logic [2:0] REG_SPARE_LO = 3'd5;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   typedef enum int {WORD_ZERO, WORD_ONES, WORD_RANDOM, WORD_LETTERS} word_fill_type;

   typedef struct packed {
      logic [lgpc_pkg::TALLY_W-1:0] match_count;
      logic                         header;
      logic [lgpc_pkg::TOTAL_W-1:0] total;
   } line_result_type;

   // One directed line: settings, leading text, a run of one fill byte, and the
   // expected counts where they are obvious.
   typedef struct packed {
      logic [5:0]   plen;
      logic [63:0]  pword;
      logic [127:0] text;
      logic [4:0]   tlen;
      logic [7:0]   fill_byte;
      logic [9:0]   fill_count;
      logic         ends;
      logic         typed;
      logic [9:0]   exp_matches;
      logic         exp_header;
   } line_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid     = 1'b0;
   logic                                req_stall;
   logic [lgpc_pkg::BYTE_W-1:0]         req_text_byte = '0;
   logic                                req_line_end  = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall     = 1'b0;
   logic [lgpc_pkg::TALLY_W-1:0]        rsp_line_matches;
   logic                                rsp_header_valid;
   logic [lgpc_pkg::TOTAL_W-1:0]        rsp_total_matches;
   logic                                csr_psel      = 1'b0;
   logic                                csr_penable   = 1'b0;
   logic                                csr_pwrite    = 1'b0;
   logic [lgpc_pkg::CSR_ADDR_W-1:0]     csr_paddr     = '0;
   logic [lgpc_pkg::CSR_DATA_W-1:0]     csr_pwdata    = '0;
   logic [lgpc_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   line_gated_pattern_counter_unit DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Directed lines. Rows 11 and 12 form one line with a pattern change inside it.
   line_row_type directed_lines [NUM_ROWS] = '{
      '{6'd1,  64'h0,      "_|",        5'd2, 8'h00, 10'd0,    1'b1, 1'b1, 10'd0,    1'b1},
      '{6'd2,  64'h6261,   "x_|ababab", 5'd9, 8'h00, 10'd0,    1'b1, 1'b1, 10'd3,    1'b1},
      '{6'd2,  64'h6261,   "|_abab",    5'd6, 8'h00, 10'd0,    1'b1, 1'b1, 10'd0,    1'b0},
      '{6'd2,  64'h6261,   "abab",      5'd4, 8'h00, 10'd0,    1'b1, 1'b1, 10'd0,    1'b0},
      '{6'd2,  64'h6261,   "ab_",       5'd3, 8'h00, 10'd0,    1'b1, 1'b1, 10'd0,    1'b0},
      '{6'd2,  64'h6261,   "_ab|_|ab",  5'd8, 8'h00, 10'd0,    1'b1, 1'b1, 10'd2,    1'b1},
      '{6'd3,  64'h616161, "_|aaaaa",   5'd7, 8'h00, 10'd0,    1'b1, 1'b1, 10'd3,    1'b1},
      '{6'd0,  64'h7A,     "_|zz",      5'd4, 8'h00, 10'd0,    1'b1, 1'b1, 10'd2,    1'b1},
      '{6'd63, 64'h7A,     "_|zz",      5'd4, 8'h00, 10'd0,    1'b1, 1'b1, 10'd0,    1'b1},
      '{6'd2,  64'h6261,   "_|a",       5'd3, 8'h00, 10'd0,    1'b1, 1'b1, 10'd0,    1'b1},
      '{6'd2,  64'h6261,   "b_|",       5'd3, 8'h00, 10'd0,    1'b1, 1'b1, 10'd0,    1'b1},
      '{6'd1,  64'h71,     "_|qq",      5'd4, 8'h00, 10'd0,    1'b0, 1'b0, 10'd0,    1'b0},
      '{6'd1,  64'h72,     "qrr",       5'd3, 8'h00, 10'd0,    1'b1, 1'b0, 10'd0,    1'b0},
      '{6'd1,  64'hFF,     "_|",        5'd2, 8'hFF, 10'd4,    1'b1, 1'b1, 10'd4,    1'b1},
      '{6'd8,  '1,         "_|",        5'd2, 8'hFF, 10'd9,    1'b1, 1'b1, 10'd2,    1'b1},
      '{6'd1,  64'h61,     "_|",        5'd2, 8'h61, 10'd1021, 1'b0, 1'b1, 10'd1021, 1'b1},
      '{6'd1,  64'h61,     "_|",        5'd2, 8'h61, 10'd1021, 1'b1, 1'b1, 10'd1021, 1'b1},
      '{6'd1,  64'h61,     "_|",        5'd2, 8'h61, 10'd1022, 1'b1, 1'b0, 10'd0,    1'b0},
      '{6'd1,  64'h61,     "x",         5'd1, 8'h00, 10'd0,    1'b1, 1'b1, 10'd0,    1'b0},
      '{6'd1,  64'h5F,     "_|_",       5'd3, 8'h00, 10'd0,    1'b1, 1'b1, 10'd2,    1'b1},
      '{6'd1,  64'h7C,     "|_|",       5'd3, 8'h00, 10'd0,    1'b1, 1'b1, 10'd0,    1'b0}
   };

   // Predictor copy of the settings.
   logic [5:0]  cfg_len = 6'd1;
   logic [63:0] cfg_words [lgpc_pkg::WORD_COUNT] = '{default: '0};

   // Predictor copy of the line state.
   logic [lgpc_pkg::BYTE_W-1:0]  history [lgpc_pkg::PATTERN_MAX-1] = '{default: '0};
   int                           line_pos         = 0;
   logic [lgpc_pkg::TALLY_W-1:0] line_tally       = '0;
   logic                         seen_underscore  = 1'b0;
   logic                         seen_pipe        = 1'b0;
   logic                         underscore_leads = 1'b0;
   logic [lgpc_pkg::TOTAL_W-1:0] total_kept       = '0;

   line_result_type pending_lines [$];
   line_result_type oldest_line;

   int  error_count   = 0;
   int  lines_checked = 0;
   int  bytes_sent    = 0;
   int  settings_used = 0;
   int  long_holds    = 0;
   int  idle_cycles   = 0;
   bit  quiet_tail    = 1'b0;
   bit  hold_request  = 1'b0;

   function automatic int effective_len();
      if (cfg_len == 0) return 1;
      if (cfg_len > lgpc_pkg::PATTERN_MAX) return lgpc_pkg::PATTERN_MAX;
      return int'(cfg_len);
   endfunction

   function automatic logic [7:0] pattern_char(int k);
      if (k >= lgpc_pkg::PATTERN_MAX) return 8'h00;
      return cfg_words[k / 8][8 * (k % 8) +: 8];
   endfunction

   // Advances the line state by one byte and queues the line result when the
   // line ends, either by its flag or by reaching the length limit.
   task automatic count_step(input logic [7:0] value, input logic last, output bit produced);
      int              eff;
      bit              hit;
      logic [32:0]     sum;
      line_result_type res;
      eff = effective_len();
      produced = 1'b0;
      if (line_pos + 1 >= eff) begin
         hit = (value == pattern_char(eff - 1));
         for (int i = 0; i + 1 < eff; i++) begin
            if (history[i] != pattern_char(eff - 2 - i)) hit = 1'b0;
         end
         if (hit && line_tally != lgpc_pkg::TALLY_MAX) line_tally++;
      end
      if (value == lgpc_pkg::UNDERSCORE_CHAR && !seen_underscore) begin
         seen_underscore = 1'b1;
         if (!seen_pipe) underscore_leads = 1'b1;
      end
      if (value == lgpc_pkg::PIPE_CHAR) seen_pipe = 1'b1;
      for (int i = lgpc_pkg::PATTERN_MAX - 2; i > 0; i--) history[i] = history[i - 1];
      history[0] = value;
      line_pos++;
      if (last || line_pos >= lgpc_pkg::LINE_MAX - 1) begin
         res.header = underscore_leads && seen_pipe;
         res.match_count = res.header ? line_tally : '0;
         sum = {1'b0, total_kept} + 33'(res.match_count);
         total_kept = sum[32] ? '1 : sum[31:0];
         res.total = total_kept;
         pending_lines.push_back(res);
         produced = 1'b1;
         foreach (history[i]) history[i] = '0;
         line_pos = 0;
         line_tally = '0;
         seen_underscore = 1'b0;
         seen_pipe = 1'b0;
         underscore_leads = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("Line result %0d: %s is %0d, expected %0d", lines_checked, what, got, want);
   endtask

   // One byte transfer, with an occasional idle burst in front of it.
   task automatic send_byte(input logic [7:0] value, input logic last, output bit produced);
      int gap;
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= value;
      req_line_end <= last;
      do @(posedge clock); while (req_stall);
      count_step(value, last, produced);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Stops sending and waits until every queued line result has come back
   // and the block has had time to settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Setup phase, access phase, then the port is deselected.
   task automatic csr_write(input logic [2:0] index, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         lgpc_pkg::REG_PATTERN_LENGTH:  cfg_len = value[5:0];
         lgpc_pkg::REG_PATTERN_BYTES_0: cfg_words[0] = value;
         lgpc_pkg::REG_PATTERN_BYTES_1: cfg_words[1] = value;
         lgpc_pkg::REG_PATTERN_BYTES_2: cfg_words[2] = value;
         lgpc_pkg::REG_PATTERN_BYTES_3: cfg_words[3] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [63:0] make_word(word_fill_type mode);
      logic [63:0] w;
      w = '0;
      case (mode)
         WORD_ZERO:   w = '0;
         WORD_ONES:   w = '1;
         WORD_RANDOM: w = {$urandom, $urandom};
         default: begin
            // Mostly letters, with the header characters now and then.
            for (int k = 0; k < 8; k++) begin
               case ($urandom_range(0, 7))
                  6:       w[8 * k +: 8] = lgpc_pkg::UNDERSCORE_CHAR;
                  7:       w[8 * k +: 8] = lgpc_pkg::PIPE_CHAR;
                  default: w[8 * k +: 8] = 8'h61 + 8'($urandom_range(0, 1));
               endcase
            end
         end
      endcase
      return w;
   endfunction

   // Each phase picks a pattern length and fill style, then writes every register.
   task automatic apply_phase_settings(input int phase);
      logic [5:0]    len;
      word_fill_type mode;
      case (phase % 6)
         0: begin
            len = 6'($urandom_range(1, 4));
            mode = WORD_LETTERS;
         end
         1: begin
            len = 6'd32;
            mode = WORD_LETTERS;
         end
         2: begin
            len = 6'($urandom_range(33, 63));
            mode = WORD_ONES;
         end
         3: begin
            len = 6'd0;
            mode = WORD_RANDOM;
         end
         4: begin
            len = 6'($urandom_range(1, 63));
            mode = WORD_RANDOM;
         end
         default: begin
            len = 6'd1;
            mode = WORD_ZERO;
         end
      endcase
      drain_results();
      for (int r = 0; r < lgpc_pkg::WORD_COUNT; r++)
         csr_write(3'(lgpc_pkg::REG_PATTERN_BYTES_0 + r), make_word(mode));
      csr_write(lgpc_pkg::REG_PATTERN_LENGTH, 64'(len));
      csr_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {$urandom, $urandom});
      settings_used++;
   endtask

   function automatic logic [7:0] filler_byte(int eff);
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      return pattern_char($urandom_range(0, eff - 1));
   endfunction

   // Builds one line: mostly a good header followed by pattern copies and
   // filler, sometimes a broken header, sometimes plain noise.
   task automatic send_random_line();
      logic [7:0] line_bytes [$];
      int         eff;
      int         kind;
      int         reps;
      bit         produced;
      eff = effective_len();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         repeat ($urandom_range(1, 20)) line_bytes.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(0, 2)) line_bytes.push_back(filler_byte(eff));
         if (kind == 7) begin
            line_bytes.push_back(lgpc_pkg::PIPE_CHAR);
            line_bytes.push_back(lgpc_pkg::UNDERSCORE_CHAR);
         end else if (kind == 8) begin
            line_bytes.push_back($urandom_range(0, 1) ? lgpc_pkg::PIPE_CHAR :
                                                        lgpc_pkg::UNDERSCORE_CHAR);
         end else begin
            line_bytes.push_back(lgpc_pkg::UNDERSCORE_CHAR);
            repeat ($urandom_range(0, 2)) line_bytes.push_back(filler_byte(eff));
            line_bytes.push_back(lgpc_pkg::PIPE_CHAR);
         end
         reps = (eff > 8) ? 1 : $urandom_range(1, 3);
         repeat (reps) begin
            if ($urandom_range(0, 2) != 0) begin
               for (int k = 0; k < eff; k++) line_bytes.push_back(pattern_char(k));
            end
            repeat ($urandom_range(0, 3)) line_bytes.push_back(filler_byte(eff));
         end
      end
      foreach (line_bytes[i])
         send_byte(line_bytes[i], i == line_bytes.size() - 1, produced);
   endtask

   // Result checker: each transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lines.size() == 0) begin
            report_mismatch("unexpected result, total_matches", rsp_total_matches, 0);
         end else begin
            oldest_line = pending_lines.pop_front();
            if (rsp_line_matches != oldest_line.match_count)
               report_mismatch("line_matches", rsp_line_matches, oldest_line.match_count);
            if (rsp_header_valid != oldest_line.header)
               report_mismatch("header_valid", rsp_header_valid, oldest_line.header);
            if (rsp_total_matches != oldest_line.total)
               report_mismatch("total_matches", rsp_total_matches, oldest_line.total);
         end
         lines_checked++;
      end
   end

   // Result side: random stall bursts, one long hold-off on request, and no
   // stalls at all once the tail of the run starts.
   initial begin : result_side
      int   span;
      logic hold;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold = 1'b1;
            span = LONG_HOLD;
            long_holds++;
         end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            hold = 1'b1;
            span = $urandom_range(1, 9);
         end else begin
            hold = 1'b0;
            span = $urandom_range(1, 16);
         end
         rsp_stall <= hold;
         repeat (span) @(negedge clock);
      end
   end

   // Watchdog: ends the run when no transfer of any kind happens for too long.
   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      line_row_type row;
      int           count;
      int           tl;
      int           phase;
      int           directed_bytes;
      int           random_lines;
      logic [7:0]   value;
      bit           produced;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed lines; settings change only while the block is idle.
      foreach (directed_lines[r]) begin
         row = directed_lines[r];
         if (row.plen != cfg_len || row.pword != cfg_words[0]) begin
            drain_results();
            if (row.plen != cfg_len)
               csr_write(lgpc_pkg::REG_PATTERN_LENGTH, 64'(row.plen));
            if (row.pword != cfg_words[0])
               csr_write(lgpc_pkg::REG_PATTERN_BYTES_0, row.pword);
         end
         tl = int'(row.tlen);
         count = tl + int'(row.fill_count);
         for (int k = 0; k < count; k++) begin
            value = (k < tl) ? row.text[8 * (tl - 1 - k) +: 8] : row.fill_byte;
            send_byte(value, row.ends && (k == count - 1), produced);
            if (produced && row.typed && k == count - 1) begin
               pending_lines[pending_lines.size() - 1].match_count = row.exp_matches;
               pending_lines[pending_lines.size() - 1].header = row.exp_header;
            end
         end
      end
      directed_bytes = bytes_sent;

      // Random phases, each with its own settings. The first one holds the
      // result side off for a long stretch while lines keep coming.
      phase = 0;
      random_lines = 0;
      while (bytes_sent - directed_bytes < RANDOM_ITEMS || random_lines < RANDOM_LINES) begin
         apply_phase_settings(phase);
         if (phase == 0) hold_request = 1'b1;
         repeat ((effective_len() > 8) ? 3 : 8) begin
            send_random_line();
            random_lines++;
         end
         phase++;
      end

      // Tail of the run at full rate on both sides.
      drain_results();
      quiet_tail = 1'b1;
      repeat (TAIL_LINES) send_random_line();
      drain_results();
      repeat (END_CYCLES) @(posedge clock);

      $display("Covered %0d text bytes in %0d checked line results over %0d pattern settings,",
               bytes_sent, lines_checked, settings_used + 1);
      $display("including forced line ends, a pattern change inside a line and %0d long hold-off.",
               long_holds);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
